// ----- hdl/wtm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wtm_pkg;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ONE_BYTE  = 8'h3F;
  localparam logic [4:0] COUNT_MAX = 5'd31;
  localparam int         CFG_AW    = 3;
  localparam int         CFG_DW    = 64;

  typedef enum logic [CFG_AW-1:0] {
    REG_PATTERN_LO  = 3'd0,
    REG_PATTERN_HI  = 3'd1,
    REG_PATTERN_LEN = 3'd2,
    REG_PREFIX_LEN  = 3'd3,
    REG_FIELD_ID    = 3'd4
  } cfg_reg_t;

  // Signals that one cell hands to the next position in the same cycle.
  typedef struct packed {
    logic clos_pre;
    logic adv;
    logic clos_post;
  } link_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic [7:0] term_byte;
    logic       step;
    logic       restart;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/wtm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface wtm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] term_byte;
  logic [7:0] term_field;
  logic       last;

  modport source(output valid, output term_byte, output term_field, output last,
                 input ready);
  modport sink(input valid, input term_byte, input term_field, input last,
               output ready);
endinterface

interface wtm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic end_of_enum;

  modport source(output valid, output matched, output end_of_enum, input ready);
  modport sink(input valid, input matched, input end_of_enum, output ready);
endinterface

`default_nettype wire

// ----- hdl/wtm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wtm_cell #(
  parameter int POS = 0,
  parameter int LW  = 5
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire wtm_pkg::cell_ctl_t ctl,
  input  wire logic [7:0]        pat,
  input  wire logic [LW-1:0]     eff_len,
  input  wire logic [LW-1:0]     eff_pre,
  input  wire wtm_pkg::link_t    link_in,
  output wtm_pkg::link_t         link_out,
  output logic                   active_post
);
  import wtm_pkg::*;

  localparam logic [LW-1:0] POS_L = LW'(POS);
  localparam logic          RESET_ACTIVE = (POS == 0);

  logic active_r;
  logic active_nxt;
  logic in_range;
  logic wild;
  logic star_w;
  logic one_w;
  logic active_pre;
  logic clos_pre_w;
  logic adv_w;
  logic clos_post_w;

  assign in_range   = POS_L < eff_len;
  assign wild       = POS_L >= eff_pre;
  assign star_w     = wild && (pat == STAR_BYTE);
  assign one_w      = wild && (pat == ONE_BYTE);
  assign active_pre = active_r | link_in.clos_pre;

  assign clos_pre_w  = active_pre & star_w & in_range;
  assign adv_w       = active_pre & in_range & ~star_w
                       & (one_w | (pat == ctl.term_byte));
  assign active_post = clos_pre_w | link_in.adv | link_in.clos_post;
  assign clos_post_w = active_post & star_w & in_range;
  assign link_out    = {clos_pre_w, adv_w, clos_post_w};

  always_comb begin
    active_nxt = active_r;
    if (ctl.step) begin
      active_nxt = ctl.restart ? RESET_ACTIVE : active_post;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= RESET_ACTIVE;
    end else begin
      active_r <= active_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wildcard_term_matcher_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Matches terms, streamed one byte per transfer, against a glob pattern of up to
// 16 bytes held in the configuration registers. The first prefix_len bytes are
// compared literally; after them '*' matches any run of bytes and '?' matches one
// byte. One input transfer can be taken every clock cycle; a row of MAX_PATTERN
// cells, one per pattern position, updates the set of active positions for each
// byte, with star closure rippling along the row. The transfer that carries the
// last byte of a term produces one result in the cycle after it, held in an output
// register. Input stalls only while a result waits and the result channel is not
// ready. end_of_enum is sticky and only reset clears it.
module wildcard_term_matcher_core #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  wtm_in_if.sink                            in_ch,
  wtm_out_if.source                         out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [wtm_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [wtm_pkg::CFG_DW-1:0]   cfg_wdata
);
  import wtm_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int CW = (LW > 5) ? LW : 5;

  logic [63:0] pattern_lo_r;
  logic [63:0] pattern_hi_r;
  logic [4:0]  pattern_len_r;
  logic [3:0]  prefix_len_r;
  logic [7:0]  field_id_r;

  logic [4:0]  byte_count_r;
  logic [4:0]  byte_count_nxt;
  logic        prefix_equal_r;
  logic        prefix_equal_nxt;
  logic        end_flag_r;
  logic        end_flag_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_matched_r;
  logic        out_matched_nxt;

  logic [LW-1:0]       eff_len;
  logic [LW-1:0]       eff_pre;
  logic [127:0]        pat_all;
  logic [7:0]          pfx_byte;
  logic                in_pfx;
  logic                accept;
  cell_ctl_t           ctl;
  link_t               link [0:MAX_PATTERN];
  wire logic [MAX_PATTERN:0] post_vec;

  assign accept      = in_ch.valid & in_ch.ready;
  assign in_ch.ready = ~out_valid_r | out_ch.ready;

  assign eff_len = (CW'(pattern_len_r) > CW'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
                                                           : LW'(pattern_len_r);
  assign eff_pre = (CW'(prefix_len_r) > CW'(eff_len)) ? eff_len : LW'(prefix_len_r);

  assign ctl = {in_ch.term_byte, accept, in_ch.last};

  assign link[0] = '0;

  for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
    logic [7:0] pat;
    if (p < 8) begin : g_lo
      assign pat = pattern_lo_r[8*p +: 8];
    end else if (p < 16) begin : g_hi
      assign pat = pattern_hi_r[8*(p-8) +: 8];
    end else begin : g_zero
      assign pat = 8'h00;
    end

    wtm_cell #(
      .POS (p),
      .LW  (LW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .pat         (pat),
      .eff_len     (eff_len),
      .eff_pre     (eff_pre),
      .link_in     (link[p]),
      .link_out    (link[p+1]),
      .active_post (post_vec[p])
    );
  end

  assign post_vec[MAX_PATTERN] = link[MAX_PATTERN].adv | link[MAX_PATTERN].clos_post;

  assign pat_all  = {pattern_hi_r, pattern_lo_r};
  assign pfx_byte = pat_all[{byte_count_r[3:0], 3'b000} +: 8];
  assign in_pfx   = CW'(byte_count_r) < CW'(eff_pre);

  always_comb begin
    byte_count_nxt   = byte_count_r;
    prefix_equal_nxt = prefix_equal_r;
    end_flag_nxt     = end_flag_r;
    out_matched_nxt  = out_matched_r;
    out_valid_nxt    = out_valid_r & ~out_ch.ready;
    if (accept) begin
      if (in_pfx && (pfx_byte != in_ch.term_byte)) begin
        prefix_equal_nxt = 1'b0;
      end
      if (byte_count_r < COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 5'd1;
      end
      if (in_ch.last) begin
        out_valid_nxt   = 1'b1;
        out_matched_nxt = 1'b0;
        if (eff_pre != '0) begin
          if ((in_ch.term_field != field_id_r) || !prefix_equal_nxt
              || (CW'(byte_count_nxt) < CW'(eff_pre))) begin
            end_flag_nxt = 1'b1;
          end else begin
            out_matched_nxt = post_vec[eff_len];
          end
        end
        byte_count_nxt   = '0;
        prefix_equal_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_lo_r   <= '0;
      pattern_hi_r   <= '0;
      pattern_len_r  <= 5'd1;
      prefix_len_r   <= '0;
      field_id_r     <= '0;
      byte_count_r   <= '0;
      prefix_equal_r <= 1'b1;
      end_flag_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      out_matched_r  <= 1'b0;
    end else begin
      byte_count_r   <= byte_count_nxt;
      prefix_equal_r <= prefix_equal_nxt;
      end_flag_r     <= end_flag_nxt;
      out_valid_r    <= out_valid_nxt;
      out_matched_r  <= out_matched_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_PATTERN_LO:  pattern_lo_r  <= cfg_wdata;
          REG_PATTERN_HI:  pattern_hi_r  <= cfg_wdata;
          REG_PATTERN_LEN: pattern_len_r <= cfg_wdata[4:0];
          REG_PREFIX_LEN:  prefix_len_r  <= cfg_wdata[3:0];
          REG_FIELD_ID:    field_id_r    <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.matched     = out_matched_r;
  assign out_ch.end_of_enum = end_flag_r;

endmodule

`default_nettype wire

// ----- sim/wtm_match_check.sv -----
`timescale 1ns / 1ps

module wtm_match_check #(
  parameter int MAX_PATTERN = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  wtm_in_if           in_ch,
  wtm_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          outstanding
);
  import wtm_pkg::*;

  typedef struct packed {
    logic matched;
    logic end_of_enum;
  } verdict_t;

  verdict_t verdict_q[$];

  logic [63:0] pat_lo, pat_hi;
  logic [4:0] pat_len;
  logic [3:0] pre_len;
  logic [7:0] fld_id;

  logic [MAX_PATTERN:0] live;
  logic [4:0] seen;
  logic prefix_ok;
  logic ended;

  function automatic logic [7:0] pattern_at(int i);
    if (i < 8) return pat_lo[8*i +: 8];
    if (i < 16) return pat_hi[8*(i-8) +: 8];
    return 8'h00;
  endfunction

  task automatic close_stars(int n, int pre);
    for (int p = pre; p < n; p++) begin
      if (live[p] && pattern_at(p) == STAR_BYTE) live[p+1] = 1'b1;
    end
  endtask

  task automatic restart_term();
    live = '0;
    live[0] = 1'b1;
    seen = '0;
    prefix_ok = 1'b1;
  endtask

  task automatic advance_term(input logic [7:0] b, input logic [7:0] fld, input logic fin,
                              output logic has_res, output verdict_t res);
    int n;
    int pre;
    logic [MAX_PATTERN:0] nxt;
    logic [7:0] pc;
    n = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    pre = (pre_len > n) ? n : int'(pre_len);
    close_stars(n, pre);
    nxt = '0;
    for (int p = 0; p < n; p++) begin
      if (live[p]) begin
        pc = pattern_at(p);
        if (p >= pre && pc == STAR_BYTE) begin
          nxt[p] = 1'b1;
        end else if ((p >= pre && pc == ONE_BYTE) || pc == b) begin
          nxt[p+1] = 1'b1;
        end
      end
    end
    live = nxt;
    close_stars(n, pre);
    if (seen < pre && pattern_at(int'(seen)) != b) prefix_ok = 1'b0;
    if (seen < COUNT_MAX) seen = seen + 5'd1;
    has_res = fin;
    res = '0;
    if (fin) begin
      if (pre != 0) begin
        if (fld != fld_id || !prefix_ok || seen < pre) begin
          ended = 1'b1;
        end else begin
          res.matched = live[n];
        end
      end
      res.end_of_enum = ended;
      restart_term();
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    verdict_t got;
    logic has_res;
    if (!rst_n) begin
      pat_lo = '0;
      pat_hi = '0;
      pat_len = 5'd1;
      pre_len = '0;
      fld_id = '0;
      ended = 1'b0;
      restart_term();
      verdict_q.delete();
      outstanding <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.matched !== want.matched)
            report_mismatch($sformatf("matched %b, expected %b", out_ch.matched, want.matched));
          if (out_ch.end_of_enum !== want.end_of_enum)
            report_mismatch($sformatf("end_of_enum %b, expected %b",
                                      out_ch.end_of_enum, want.end_of_enum));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_term(in_ch.term_byte, in_ch.term_field, in_ch.last, has_res, got);
        if (has_res) verdict_q.push_back(got);
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_PATTERN_LO:  pat_lo = cfg_wdata;
          REG_PATTERN_HI:  pat_hi = cfg_wdata;
          REG_PATTERN_LEN: pat_len = cfg_wdata[4:0];
          REG_PREFIX_LEN:  pre_len = cfg_wdata[3:0];
          REG_FIELD_ID:    fld_id = cfg_wdata[7:0];
          default: ;
        endcase
      end
      outstanding <= verdict_q.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import wtm_pkg::*;

  localparam int LIMIT = 400000;
  localparam int TARGET_ITEMS = 900;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_reg_t cfg_addr;
  logic [63:0] cfg_wdata;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int items_sent = 0;
  logic calm = 1'b0;

  logic [7:0] pat_shadow [16];
  logic [4:0] len_reg;
  logic [3:0] pre_reg;
  logic [7:0] fid_reg;
  int eff_n;
  int eff_pre;
  logic [7:0] term_buf[$];

  wtm_in_if in_ch();
  wtm_out_if out_ch();

  wildcard_term_matcher_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  wtm_match_check match_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      4: return STAR_BYTE;
      5: return ONE_BYTE;
      default: return 8'h61 + 8'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin : ready_gen
    int stall;
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [7:0] fld, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.term_byte <= b;
    in_ch.term_field <= fld;
    in_ch.last <= fin;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_term(input logic [7:0] fld);
    int sz;
    sz = term_buf.size();
    for (int i = 0; i < sz; i++) begin
      send_byte(term_buf[i], (i == sz - 1) ? fld : 8'($urandom_range(0, 255)), i == sz - 1);
    end
  endtask

  task automatic send_text(input string s, input logic [7:0] fld);
    term_buf.delete();
    for (int i = 0; i < s.len(); i++) term_buf.push_back(s[i]);
    send_term(fld);
  endtask

  // Drains the result channel so that the block is idle before a register write.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_pattern();
    cfg_reg_t r;
    logic [63:0] lo;
    logic [63:0] hi;
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = pat_shadow[i];
      hi[8*i +: 8] = pat_shadow[i+8];
    end
    r = REG_PATTERN_LO;
    repeat (5) begin
      cfg_we <= 1'b1;
      cfg_addr <= r;
      case (r)
        REG_PATTERN_LO:  cfg_wdata <= lo;
        REG_PATTERN_HI:  cfg_wdata <= hi;
        REG_PATTERN_LEN: cfg_wdata <= {27'($urandom), $urandom, len_reg};
        REG_PREFIX_LEN:  cfg_wdata <= {28'($urandom), $urandom, pre_reg};
        default:         cfg_wdata <= {24'($urandom), $urandom, fid_reg};
      endcase
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
    eff_n = (len_reg > 16) ? 16 : int'(len_reg);
    eff_pre = (pre_reg > eff_n) ? eff_n : int'(pre_reg);
  endtask

  task automatic choose_pattern(input int phase_no);
    int span;
    int pre;
    int r;
    for (int i = 0; i < 16; i++) pat_shadow[i] = 8'($urandom_range(0, 255));
    span = (phase_no == 1) ? 16 : $urandom_range(1, 16);
    pre = (phase_no == 1) ? 15 : $urandom_range(1, (span < 15) ? span : 15);
    for (int i = 0; i < span; i++) begin
      r = $urandom_range(0, 99);
      if (i < pre) begin
        if (r < 5) pat_shadow[i] = STAR_BYTE;
        else if (r < 10) pat_shadow[i] = ONE_BYTE;
        else pat_shadow[i] = 8'h61 + 8'($urandom_range(0, 3));
      end else begin
        if (r < 40) pat_shadow[i] = STAR_BYTE;
        else if (r < 65) pat_shadow[i] = ONE_BYTE;
        else pat_shadow[i] = 8'h61 + 8'($urandom_range(0, 3));
      end
    end
    len_reg = 5'(span);
    pre_reg = 4'(pre);
    case ($urandom_range(0, 9))
      0: fid_reg = 8'h00;
      1: fid_reg = 8'hFF;
      default: fid_reg = 8'($urandom_range(0, 255));
    endcase
    if (phase_no > 2 && $urandom_range(0, 4) == 0) begin
      len_reg = 5'($urandom_range(0, 31));
      pre_reg = 4'($urandom_range(0, 15));
    end
    case (phase_no)
      0: begin
        for (int i = 0; i < 16; i++) pat_shadow[i] = 8'hFF;
        len_reg = 5'd16;
        pre_reg = 4'd15;
        fid_reg = 8'hFF;
      end
      1: len_reg = 5'd31;
      2: begin
        for (int i = 0; i < 16; i++) pat_shadow[i] = 8'h00;
        len_reg = 5'd0;
        pre_reg = 4'd0;
        fid_reg = 8'h00;
      end
      default: ;
    endcase
  endtask

  task automatic build_match(input int star_min, input int star_max);
    logic [7:0] b;
    term_buf.delete();
    for (int p = 0; p < eff_n; p++) begin
      b = pat_shadow[p];
      if (p < eff_pre) term_buf.push_back(b);
      else if (b == STAR_BYTE) repeat ($urandom_range(star_min, star_max)) term_buf.push_back(rand_byte());
      else if (b == ONE_BYTE) term_buf.push_back(8'($urandom_range(0, 255)));
      else term_buf.push_back(b);
    end
    if (term_buf.size() == 0) term_buf.push_back(rand_byte());
  endtask

  task automatic corrupt_term();
    int pos;
    pos = $urandom_range(0, term_buf.size() - 1);
    case ($urandom_range(0, 3))
      0: term_buf[pos] = term_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
      1: if (term_buf.size() > 1) void'(term_buf.pop_back());
      2: term_buf.push_back(rand_byte());
      default: while (term_buf.size() > pos + 1) void'(term_buf.pop_back());
    endcase
  endtask

  task automatic random_term();
    int r;
    logic [7:0] fld;
    r = $urandom_range(0, 99);
    fld = fid_reg;
    if (r < 50) begin
      build_match(0, 3);
    end else if (r < 65) begin
      build_match(0, 3);
      corrupt_term();
    end else if (r < 72) begin
      build_match(0, 3);
      fld = fid_reg ^ 8'($urandom_range(1, 255));
    end else if (r < 80) begin
      build_match(6, 14);
      while (term_buf.size() < 32) term_buf.push_back(rand_byte());
    end else begin
      term_buf.delete();
      repeat ($urandom_range(1, 12)) term_buf.push_back(rand_byte());
      if ($urandom_range(0, 1)) fld = 8'($urandom_range(0, 255));
    end
    send_term(fld);
  endtask

  initial begin : stimulus
    int phase_no;
    int target;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_PATTERN_LO;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.term_byte <= '0;
    in_ch.term_field <= '0;
    in_ch.last <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // With the registers at their reset values the prefix is empty.
    term_buf.delete();
    term_buf.push_back(8'h00);
    term_buf.push_back(8'hFF);
    send_term(8'hFF);
    settle();

    // Pattern "a?*x?*" with the first two bytes literal.
    pat_shadow = '{8'h61, ONE_BYTE, STAR_BYTE, 8'h78, ONE_BYTE, STAR_BYTE,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    len_reg = 5'd6;
    pre_reg = 4'd2;
    fid_reg = 8'h5A;
    program_pattern();
    send_text("a?x7", 8'h5A);
    send_text("a?zx!", 8'h5A);
    send_text("a?y7", 8'h5A);
    send_text("a", 8'h5A);
    send_text("aXx7", 8'h5A);
    send_text("a?x7", 8'hA5);
    settle();

    phase_no = 0;
    while (items_sent < TARGET_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      choose_pattern(phase_no);
      program_pattern();
      target = items_sent + $urandom_range(40, 120);
      while (items_sent < target) random_term();
      settle();
      phase_no++;
    end

    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
